@@ hw/rtl/ntt_pkg.sv @@
// Shared types, codes and reset values for the number theoretic transform core.
// No dependencies; every other file of the block imports this package.
package ntt_pkg;

  localparam int CoefW        = 62;
  localparam int MaxPointsDef = 1024;
  localparam int PaddrW       = 5;
  localparam int PdataW       = 64;

  typedef logic [CoefW-1:0] coef_t;

  // Input item modes.
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_IDLE  = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_VALUE = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_ROOT    = 2'd1;
  localparam logic [1:0] REG_INVERSE = 2'd2;
  localparam logic [1:0] REG_LOG_LEN = 2'd3;

  localparam coef_t      MODULUS_RST = coef_t'(998244353);
  localparam coef_t      ROOT_RST    = coef_t'(3);
  localparam logic [3:0] LOG_LEN_RST = 4'd10;

endpackage

@@ hw/rtl/ntt_mulmod.sv @@
// Bit-serial modular multiplier: res = (a * b) mod m, one bit of b per cycle.
// Operand a must already be below m. Depends on ntt_pkg.
module ntt_mulmod (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  ntt_pkg::coef_t a,
  input  ntt_pkg::coef_t b,
  input  ntt_pkg::coef_t m,
  output ntt_pkg::coef_t res,
  output logic          done
);
  import ntt_pkg::*;

  localparam int CntW = $clog2(CoefW);

  coef_t            acc;
  coef_t            a_q;
  coef_t            b_q;
  coef_t            m_q;
  logic [CntW-1:0]  cnt;
  logic             active;
  logic [CoefW:0]   dbl;
  logic [CoefW:0]   dbl_red;
  logic [CoefW:0]   add;
  logic [CoefW:0]   acc_next;

  // Double the partial result, reduce, then conditionally add a and reduce.
  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    add     = dbl_red + {1'b0, a_q};
    if (b_q[cnt]) begin
      acc_next = (add >= {1'b0, m_q}) ? add - {1'b0, m_q} : add;
    end else begin
      acc_next = dbl_red;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        acc    <= '0;
        a_q    <= a;
        b_q    <= b;
        m_q    <= m;
        cnt    <= CntW'(CoefW - 1);
        active <= 1'b1;
      end else if (active) begin
        acc <= acc_next[CoefW-1:0];
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign res = acc;

endmodule

@@ hw/rtl/number_theoretic_transform_core.sv @@
// Radix-2 number theoretic transform core: coefficient memory, sequencer, config port.
// A write, rejected read or unused-mode word raises done from S_WR, S_RD or S_FIN; a good read goes on to S_RD2.
// A transform runs the bit-reversal sweep, then (N/2)*log2(N) butterflies of three
// serial multiplies each on the one shared bit-serial multiplier, plus square-and-multiply
// twiddle powers per stage and, for an inverse, a final scaling pass. busy stays high until done.
// Synchronous reset clears control, the result word and the configuration registers; the memory is not cleared.
module number_theoretic_transform_core #(
  parameter int MAX_POINTS = ntt_pkg::MaxPointsDef
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  mode,
  input  logic [9:0]                  index,
  input  ntt_pkg::coef_t              value,
  output logic                        done,
  output ntt_pkg::coef_t              data,
  output logic [1:0]                  status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ntt_pkg::PaddrW-1:0]  paddr,
  input  logic [ntt_pkg::PdataW-1:0]  pwdata,
  output logic [ntt_pkg::PdataW-1:0]  prdata,
  output logic                        pready
);
  import ntt_pkg::*;

  // The usable length is the largest power of two that fits MAX_POINTS.
  localparam int MaxLog = $clog2(MAX_POINTS + 1) - 1;
  localparam int AW     = MaxLog;
  localparam int Depth  = 1 << AW;
  localparam int LgW    = $clog2(MaxLog + 1);
  localparam int StgW   = LgW + 1;
  localparam int NW     = AW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_WR, S_RD, S_RD2, S_XF, S_FIN,
    S_BR, S_BR_J, S_BR_WI, S_BR_WJ,
    S_ST_TOP, S_ST_STEP1, S_ST_STEP2, S_BF_INIT, S_BF_TOP, S_BF_V, S_BF_VD,
    S_BF_U, S_BF_UD, S_BF_WB, S_BF_WD,
    S_SC_INIT, S_SC_TOP, S_SC_M, S_SC_W,
    S_PW_START, S_PW_BASE, S_PW_LOOP, S_PW_R, S_PW_SQ, S_PW_B2,
    S_MUL_WAIT
  } state_t;

  // Configuration registers.
  coef_t      modulus;
  coef_t      root;
  logic       inverse;
  logic [3:0] log_length;

  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus    <= MODULUS_RST;
      root       <= ROOT_RST;
      inverse    <= 1'b0;
      log_length <= LOG_LEN_RST;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_MODULUS: modulus    <= pwdata[CoefW-1:0];
        REG_ROOT:    root       <= pwdata[CoefW-1:0];
        REG_INVERSE: inverse    <= pwdata[0];
        REG_LOG_LEN: log_length <= pwdata[3:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_MODULUS: prdata = PdataW'(modulus);
      REG_ROOT:    prdata = PdataW'(root);
      REG_INVERSE: prdata = PdataW'(inverse);
      REG_LOG_LEN: prdata = PdataW'(log_length);
      default:     prdata = '0;
    endcase
  end

  // Effective log length and transform length.
  logic [LgW-1:0] lg;
  logic [NW-1:0]  n_len;
  always_comb begin
    if ({1'b0, log_length} > 5'(MaxLog)) begin
      lg = LgW'(MaxLog);
    end else begin
      lg = LgW'(log_length);
    end
    n_len = NW'(1) << lg;
  end

  // Sequencer registers.
  state_t         state;
  state_t         mul_ret;
  state_t         pow_ret;
  logic [9:0]     idx_q;
  coef_t          val_q;
  logic [NW-1:0]  i_cnt;
  logic [NW-1:0]  s_cnt;
  logic [NW-1:0]  k_cnt;
  logic [StgW-1:0] stg;
  coef_t          w;
  coef_t          step;
  coef_t          v_q;
  coef_t          diff_q;
  coef_t          tmp_q;
  coef_t          scale;
  coef_t          pow_base;
  coef_t          pow_exp;
  coef_t          pow_r;
  logic           mm_go;
  coef_t          mm_a;
  coef_t          mm_b;
  coef_t          mm_res;
  logic           mm_done;

  ntt_mulmod u_mulmod (
    .clk  (clk),
    .rst  (rst),
    .go   (mm_go),
    .a    (mm_a),
    .b    (mm_b),
    .m    (modulus),
    .res  (mm_res),
    .done (mm_done)
  );

  // Coefficient memory, one write and one read port, registered read data.
  coef_t          mem [Depth];
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  coef_t          mem_wdata;
  logic [AW-1:0]  mem_raddr;
  coef_t          mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // Address helpers.
  logic [AW-1:0] idx_addr;
  logic          idx_bad;
  logic [AW-1:0] rev_i;
  logic [NW-1:0] half;
  logic [NW-1:0] len;
  logic [AW-1:0] addr_top;
  logic [AW-1:0] addr_bot;
  logic [CoefW:0] sum_raw;
  coef_t          sum_red;
  logic [CoefW:0] diff_raw;
  coef_t          diff_red;

  always_comb begin
    idx_addr = AW'(idx_q);
    idx_bad  = (idx_q >> lg) != '0;
    rev_i    = '0;
    for (int b = 0; b < AW; b++) begin
      if (b < int'(lg)) begin
        rev_i[int'(lg) - 1 - b] = i_cnt[b];
      end
    end
    half     = NW'(1) << (stg - 1'b1);
    len      = NW'(1) << stg;
    addr_top = AW'(s_cnt + k_cnt);
    addr_bot = AW'(s_cnt + k_cnt + half);
    // Butterfly: mm_res holds u, v_q holds the twiddled lower value.
    sum_raw  = {1'b0, mm_res} + {1'b0, v_q};
    sum_red  = (sum_raw >= {1'b0, modulus}) ? CoefW'(sum_raw - {1'b0, modulus})
                                            : CoefW'(sum_raw);
    diff_raw = {1'b0, mm_res} + {1'b0, modulus} - {1'b0, v_q};
    diff_red = (diff_raw >= {1'b0, modulus}) ? CoefW'(diff_raw - {1'b0, modulus})
                                             : CoefW'(diff_raw);
  end

  // Memory port control per state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    case (state)
      S_WR: begin
        mem_we    = !idx_bad && (val_q < modulus);
        mem_waddr = idx_addr;
        mem_wdata = val_q;
      end
      S_RD:     mem_raddr = idx_addr;
      S_BR:     mem_raddr = AW'(i_cnt);
      S_BR_J:   mem_raddr = rev_i;
      S_BR_WI: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(i_cnt);
        mem_wdata = mem_rdata;
      end
      S_BR_WJ: begin
        mem_we    = 1'b1;
        mem_waddr = rev_i;
        mem_wdata = tmp_q;
      end
      S_BF_TOP: mem_raddr = addr_bot;
      S_BF_VD:  mem_raddr = addr_top;
      S_BF_UD: begin
        mem_we    = 1'b1;
        mem_waddr = addr_top;
        mem_wdata = sum_red;
      end
      S_BF_WB: begin
        mem_we    = 1'b1;
        mem_waddr = addr_bot;
        mem_wdata = diff_q;
      end
      S_SC_TOP: mem_raddr = AW'(i_cnt);
      S_SC_W: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(i_cnt);
        mem_wdata = mm_res;
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  // Sequencer with registered result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      data   <= '0;
      status <= STATUS_OK;
      mm_go  <= 1'b0;
    end else begin
      done  <= 1'b0;
      mm_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            idx_q  <= index;
            val_q  <= value;
            case (mode)
              MODE_WRITE: state <= S_WR;
              MODE_RUN:   state <= S_XF;
              MODE_READ:  state <= S_RD;
              default:    state <= S_FIN;
            endcase
          end
        end
        S_WR: begin
          done   <= 1'b1;
          data   <= '0;
          status <= idx_bad ? STATUS_RANGE :
                    (val_q >= modulus) ? STATUS_VALUE : STATUS_OK;
          state  <= S_IDLE;
        end
        S_RD: begin
          if (idx_bad) begin
            done   <= 1'b1;
            data   <= '0;
            status <= STATUS_RANGE;
            state  <= S_IDLE;
          end else begin
            state <= S_RD2;
          end
        end
        S_RD2: begin
          done   <= 1'b1;
          data   <= mem_rdata;
          status <= STATUS_OK;
          state  <= S_IDLE;
        end
        S_XF: begin
          i_cnt <= NW'(1);
          stg   <= StgW'(1);
          state <= (modulus < coef_t'(3)) ? S_FIN : S_BR;
        end
        S_FIN: begin
          done   <= 1'b1;
          data   <= '0;
          status <= STATUS_OK;
          state  <= S_IDLE;
        end
        // Bit-reversal permutation, swapping each pair once.
        S_BR: begin
          if (i_cnt == n_len) begin
            state <= S_ST_TOP;
          end else if (i_cnt < NW'(rev_i)) begin
            state <= S_BR_J;
          end else begin
            i_cnt <= i_cnt + 1'b1;
          end
        end
        S_BR_J: begin
          tmp_q <= mem_rdata;
          state <= S_BR_WI;
        end
        S_BR_WI: state <= S_BR_WJ;
        S_BR_WJ: begin
          i_cnt <= i_cnt + 1'b1;
          state <= S_BR;
        end
        // Per stage twiddle step; after the last stage, the inverse scale factor or the finish.
        S_ST_TOP: begin
          if (stg > StgW'(lg)) begin
            if (inverse) begin
              pow_base <= CoefW'(n_len);
              pow_exp  <= modulus - coef_t'(2);
              pow_ret  <= S_SC_INIT;
              state    <= S_PW_START;
            end else begin
              state <= S_FIN;
            end
          end else begin
            pow_base <= root;
            pow_exp  <= (modulus - coef_t'(1)) >> stg;
            pow_ret  <= S_ST_STEP1;
            state    <= S_PW_START;
          end
        end
        S_ST_STEP1: begin
          step <= pow_r;
          if (inverse) begin
            pow_base <= pow_r;
            pow_exp  <= modulus - coef_t'(2);
            pow_ret  <= S_ST_STEP2;
            state    <= S_PW_START;
          end else begin
            state <= S_BF_INIT;
          end
        end
        S_ST_STEP2: begin
          step  <= pow_r;
          state <= S_BF_INIT;
        end
        // Butterflies of one stage.
        S_BF_INIT: begin
          s_cnt <= '0;
          k_cnt <= '0;
          w     <= coef_t'(1);
          state <= S_BF_TOP;
        end
        S_BF_TOP: begin
          if (s_cnt == n_len) begin
            stg   <= stg + 1'b1;
            state <= S_ST_TOP;
          end else if (k_cnt == half) begin
            s_cnt <= s_cnt + len;
            k_cnt <= '0;
            w     <= coef_t'(1);
          end else begin
            state <= S_BF_V;
          end
        end
        S_BF_V: begin
          mm_go   <= 1'b1;
          mm_a    <= w;
          mm_b    <= mem_rdata;
          mul_ret <= S_BF_VD;
          state   <= S_MUL_WAIT;
        end
        S_BF_VD: begin
          v_q   <= mm_res;
          state <= S_BF_U;
        end
        S_BF_U: begin
          // Reduce the upper value, which may be stale from an older modulus.
          mm_go   <= 1'b1;
          mm_a    <= coef_t'(1);
          mm_b    <= mem_rdata;
          mul_ret <= S_BF_UD;
          state   <= S_MUL_WAIT;
        end
        S_BF_UD: begin
          diff_q <= diff_red;
          state  <= S_BF_WB;
        end
        S_BF_WB: begin
          mm_go   <= 1'b1;
          mm_a    <= w;
          mm_b    <= step;
          mul_ret <= S_BF_WD;
          state   <= S_MUL_WAIT;
        end
        S_BF_WD: begin
          w     <= mm_res;
          k_cnt <= k_cnt + 1'b1;
          state <= S_BF_TOP;
        end
        // Inverse length scaling.
        S_SC_INIT: begin
          scale <= pow_r;
          i_cnt <= '0;
          state <= S_SC_TOP;
        end
        S_SC_TOP: state <= (i_cnt == n_len) ? S_FIN : S_SC_M;
        S_SC_M: begin
          mm_go   <= 1'b1;
          mm_a    <= scale;
          mm_b    <= mem_rdata;
          mul_ret <= S_SC_W;
          state   <= S_MUL_WAIT;
        end
        S_SC_W: begin
          i_cnt <= i_cnt + 1'b1;
          state <= S_SC_TOP;
        end
        // Square-and-multiply power; returns through pow_ret with pow_r.
        S_PW_START: begin
          mm_go   <= 1'b1;
          mm_a    <= coef_t'(1);
          mm_b    <= pow_base;
          mul_ret <= S_PW_BASE;
          state   <= S_MUL_WAIT;
        end
        S_PW_BASE: begin
          pow_base <= mm_res;
          pow_r    <= coef_t'(1);
          state    <= S_PW_LOOP;
        end
        S_PW_LOOP: begin
          if (pow_exp == '0) begin
            state <= pow_ret;
          end else if (pow_exp[0]) begin
            mm_go   <= 1'b1;
            mm_a    <= pow_r;
            mm_b    <= pow_base;
            mul_ret <= S_PW_R;
            state   <= S_MUL_WAIT;
          end else begin
            state <= S_PW_SQ;
          end
        end
        S_PW_R: begin
          pow_r <= mm_res;
          state <= S_PW_SQ;
        end
        S_PW_SQ: begin
          mm_go   <= 1'b1;
          mm_a    <= pow_base;
          mm_b    <= pow_base;
          mul_ret <= S_PW_B2;
          state   <= S_MUL_WAIT;
        end
        S_PW_B2: begin
          pow_base <= mm_res;
          pow_exp  <= pow_exp >> 1;
          state    <= S_PW_LOOP;
        end
        S_MUL_WAIT: begin
          if (mm_done) begin
            state <= mul_ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result word only ends a busy period.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a busy item");

  // Accepting a word always makes the core busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");

  // Rejected items never return data.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != STATUS_OK) |-> (data == '0))
    else $error("rejected item returned data");

  // The multiplier is never restarted once the sequencer is already waiting on it.
  a_mul_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL_WAIT && $past(state == S_MUL_WAIT)) |-> !mm_go)
    else $error("multiplier restarted during wait");

endmodule

@@ verif/number_theoretic_transform_checker.sv @@
// Checker for the number theoretic transform core: watches the command, result and
// configuration channels, predicts every result word and compares it field by field.
// Depends on ntt_pkg for the coefficient type, modes, status codes and register indexes.
module number_theoretic_transform_checker #(
  parameter int MAX_POINTS = ntt_pkg::MaxPointsDef
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  mode,
  input  logic [9:0]                  index,
  input  ntt_pkg::coef_t              value,
  input  logic                        done,
  input  ntt_pkg::coef_t              data,
  input  logic [1:0]                  status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [ntt_pkg::PaddrW-1:0]  paddr,
  input  logic [ntt_pkg::PdataW-1:0]  pwdata,
  output int                          pending,
  output int                          failures,
  output int                          checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import ntt_pkg::*;

  typedef struct packed {
    coef_t      data;
    logic [1:0] status;
  } result_t;

  logic [63:0] coef_mem [MAX_POINTS];
  logic [63:0] cfg_modulus, cfg_root;
  logic        cfg_inverse;
  logic [3:0]  cfg_log_len;
  result_t     expected_results [$];

  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [63:0] r;
    r = 0;
    a = a % m;
    b = b % m;
    for (int k = 61; k >= 0; k--) begin
      r = r << 1;
      if (r >= m) r = r - m;
      if (b[k]) begin
        r = r + a;
        if (r >= m) r = r - m;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] r;
    r = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) r = mul_mod(r, b, m);
      b = mul_mod(b, b, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic int points_in_use();
    int lg;
    lg = 0;
    while (lg < int'(cfg_log_len) && (2 << lg) <= MAX_POINTS) lg++;
    return 1 << lg;
  endfunction

  // In-place transform over the first points_in_use() entries.
  function automatic void run_transform();
    logic [63:0] m, t, step, w, u, v, sum, scale;
    int n, j, bits, half;
    m = cfg_modulus;
    n = points_in_use();
    if (m < 3) return;
    j = 0;
    for (int i = 1; i < n; i++) begin
      bits = n >> 1;
      while ((j & bits) != 0) begin
        j = j ^ bits;
        bits = bits >> 1;
      end
      j = j ^ bits;
      if (i < j) begin
        t = coef_mem[i];
        coef_mem[i] = coef_mem[j];
        coef_mem[j] = t;
      end
    end
    for (int len = 2; len <= n; len = len << 1) begin
      step = pow_mod(cfg_root, (m - 1) / len, m);
      if (cfg_inverse) step = pow_mod(step, m - 2, m);
      half = len >> 1;
      for (int s = 0; s < n; s += len) begin
        w = 1;
        for (int k = 0; k < half; k++) begin
          u = coef_mem[s + k] % m;
          v = mul_mod(coef_mem[s + k + half], w, m);
          sum = u + v;
          if (sum >= m) sum = sum - m;
          coef_mem[s + k] = sum;
          coef_mem[s + k + half] = (u + m - v) % m;
          w = mul_mod(w, step, m);
        end
      end
    end
    if (cfg_inverse) begin
      scale = pow_mod(64'(n), m - 2, m);
      for (int i = 0; i < n; i++) coef_mem[i] = mul_mod(coef_mem[i], scale, m);
    end
  endfunction

  function automatic result_t predict_word(logic [1:0] md, logic [9:0] idx, coef_t val);
    result_t r;
    int n;
    r = '0;
    n = points_in_use();
    case (md)
      MODE_WRITE: begin
        if (int'(idx) >= n) r.status = STATUS_RANGE;
        else if (64'(val) >= cfg_modulus) r.status = STATUS_VALUE;
        else coef_mem[idx] = 64'(val);
      end
      MODE_RUN: run_transform();
      MODE_READ: begin
        if (int'(idx) >= n) r.status = STATUS_RANGE;
        else r.data = coef_t'(coef_mem[idx]);
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    foreach (coef_mem[i]) coef_mem[i] = 0;
    failures = 0;
    checked  = 0;
    pending  = 0;
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      cfg_modulus = 64'(MODULUS_RST);
      cfg_root    = 64'(ROOT_RST);
      cfg_inverse = 1'b0;
      cfg_log_len = LOG_LEN_RST;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          REG_MODULUS: cfg_modulus = {2'b00, pwdata[61:0]};
          REG_ROOT:    cfg_root    = {2'b00, pwdata[61:0]};
          REG_INVERSE: cfg_inverse = pwdata[0];
          REG_LOG_LEN: cfg_log_len = pwdata[3:0];
          default: ;
        endcase
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: data %0d status %0d", data, status);
          failures++;
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (data !== want.data) begin
            $error("data mismatch: expected %0d, got %0d", want.data, data);
            failures++;
          end
          if (status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, status);
            failures++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(predict_word(mode, index, value));
    end
    pending = expected_results.size();
  end

endmodule

@@ verif/number_theoretic_transform_core_test.sv @@
// Top of the testbench for the number theoretic transform core: clock, reset, the
// configuration sequence and the command words. Depends on ntt_pkg, the core and the checker.
module number_theoretic_transform_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ntt_pkg::*;

  localparam logic [63:0] COEF_MASK = (64'd1 << 62) - 1;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [1:0]          mode = MODE_WRITE;
  logic [9:0]          index = '0;
  coef_t               value = '0;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PaddrW-1:0]   paddr = '0;
  logic [PdataW-1:0]   pwdata = '0;
  logic                busy, done, pready;
  coef_t               data;
  logic [1:0]          status;
  logic [PdataW-1:0]   prdata;
  int                  pending, failures, checked;

  // Stimulus-side copy of the configuration, used only to shape words.
  logic [63:0] cur_modulus = 64'(MODULUS_RST);
  logic [3:0]  cur_log_len = LOG_LEN_RST;
  // Entries the core has actually stored; reads and transforms stay on these.
  bit          written [MaxPointsDef];
  bit          no_gaps;
  int          words_sent, runs_sent;

  number_theoretic_transform_core i_dut (
    .clk, .rst, .start, .busy, .mode, .index, .value, .done, .data, .status,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  number_theoretic_transform_checker i_checker (
    .clk, .rst, .start, .busy, .mode, .index, .value, .done, .data, .status,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .pending, .failures, .checked
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Generous ceiling: a handful of small transforms dominate the run time.
  initial begin
    #60_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int points_in_use();
    int lg;
    lg = 0;
    while (lg < int'(cur_log_len) && (2 << lg) <= MaxPointsDef) lg++;
    return 1 << lg;
  endfunction

  function automatic logic [63:0] rand_coef();
    return {$urandom, $urandom} & COEF_MASK;
  endfunction

  // Issue one command word. start is only lowered when a gap follows, so a
  // back-to-back word never sees start dropped and raised in the same step.
  task automatic send_word(logic [1:0] md, logic [9:0] idx, logic [63:0] val);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode  <= md;
    index <= idx;
    value <= coef_t'(val);
    do @(posedge clk); while (busy);
    words_sent++;
    if (md == MODE_RUN) runs_sent++;
    if (md == MODE_WRITE && int'(idx) < points_in_use() && val < cur_modulus)
      written[idx] = 1'b1;
  endtask

  // Reads and transforms must never touch an entry that was never stored.
  task automatic safe_word(logic [1:0] md, logic [9:0] idx, logic [63:0] val);
    int n;
    n = points_in_use();
    if (md == MODE_READ && int'(idx) < n && !written[idx]) begin
      send_word(MODE_WRITE, idx, rand_coef() % cur_modulus);
    end else if (md == MODE_RUN) begin
      for (int i = 0; i < n; i++)
        if (!written[i]) send_word(MODE_WRITE, 10'(i), rand_coef() % cur_modulus);
      send_word(md, idx, val);
    end else begin
      send_word(md, idx, val);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    // Let the core settle fully back to idle before returning.
    repeat (4) @(posedge clk);
  endtask

  // Setup phase, access phase held until pready, then an idle gap with psel low so the next write starts fresh.
  task automatic write_reg(logic [1:0] reg_idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({reg_idx, 3'b000});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [63:0] m, logic [63:0] r, bit inv, logic [3:0] lg);
    wait_idle();
    write_reg(REG_MODULUS, m);
    write_reg(REG_ROOT, r);
    write_reg(REG_INVERSE, 64'(inv));
    write_reg(REG_LOG_LEN, 64'(lg));
    @(posedge clk);
    cur_modulus = m & COEF_MASK;
    cur_log_len = lg;
  endtask

  // Well-formed pass: load every entry in use, transform if asked, read all back.
  task automatic load_run_read(bit do_run);
    int n;
    n = points_in_use();
    for (int i = 0; i < n; i++) send_word(MODE_WRITE, 10'(i), rand_coef() % cur_modulus);
    if (do_run) safe_word(MODE_RUN, 10'($urandom), rand_coef());
    for (int i = 0; i < n; i++) send_word(MODE_READ, 10'(i), '0);
  endtask

  // Mostly in-range writes and reads with random content, plus out-of-range
  // indexes, oversized values, the unused mode and, when allowed, the odd transform.
  task automatic random_words(int count, bit allow_run);
    int n, pick;
    logic [63:0] val;
    logic [9:0] idx;
    n = points_in_use();
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 199);
      idx  = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, n - 1));
      case ($urandom_range(0, 5))
        0: val = rand_coef();
        1: val = cur_modulus - 1;
        2: val = 0;
        default: val = rand_coef() % cur_modulus;
      endcase
      if (pick < 95) safe_word(MODE_WRITE, idx, val);
      else if (pick < 195) safe_word(MODE_READ, idx, rand_coef());
      else if (pick < 198) safe_word(MODE_IDLE, idx, val);
      else if (allow_run) safe_word(MODE_RUN, idx, val);
      else safe_word(MODE_READ, idx, '0);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    no_gaps = 1'b0;
    words_sent = 0;
    runs_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset configuration: field extremes, range
    // and value rejections, the unused mode; then more rejections and a tiny forward transform mod 17.
    send_word(MODE_WRITE, 10'd1023, 64'd0);
    send_word(MODE_READ, 10'd1023, '0);
    send_word(MODE_WRITE, 10'd0, cur_modulus - 1);
    send_word(MODE_WRITE, 10'd1, COEF_MASK);
    send_word(MODE_WRITE, 10'd2, cur_modulus);
    send_word(MODE_IDLE, 10'd1023, COEF_MASK);
    send_word(MODE_READ, 10'd0, '0);
    configure(64'd17, 64'd3, 1'b0, 4'd3);
    send_word(MODE_WRITE, 10'd8, 64'd1);
    send_word(MODE_READ, 10'd1023, '0);
    send_word(MODE_WRITE, 10'd7, 64'd16);
    send_word(MODE_WRITE, 10'd6, 64'd17);
    load_run_read(1'b1);

    // Inverse over the same small field, then back in the default prime.
    configure(64'd17, 64'd3, 1'b1, 4'd3);
    load_run_read(1'b1);
    random_words(150, 1'b1);
    configure(64'd998244353, 64'd3, 1'b1, 4'd5);
    load_run_read(1'b1);
    random_words(150, 1'b0);

    // Largest modulus and root; leaves huge values behind for later phases.
    configure(COEF_MASK, COEF_MASK - 1, 1'b0, 4'd1);
    load_run_read(1'b1);
    send_word(MODE_WRITE, 10'd1, COEF_MASK - 1);
    random_words(150, 1'b1);

    // Smallest modulus: stale entries get reduced inside the transform.
    configure(64'd3, 64'd2, 1'b1, 4'd2);
    send_word(MODE_READ, 10'd1, '0);
    safe_word(MODE_RUN, 10'd0, '0);
    load_run_read(1'b1);
    random_words(120, 1'b1);

    // Modulus below three: a transform leaves memory alone.
    configure(64'd2, 64'd2, 1'b0, 4'd2);
    safe_word(MODE_RUN, 10'd0, '0);
    for (int i = 0; i < 4; i++) send_word(MODE_READ, 10'(i), '0);
    random_words(100, 1'b1);

    // Oversized log length saturates at the full memory; no transform here.
    configure(64'd7681, 64'd17, 1'b0, 4'd15);
    random_words(200, 1'b0);

    configure(64'd12289, 64'd11, 1'b1, 4'd4);
    load_run_read(1'b1);
    random_words(250, 1'b1);
    configure(64'd7681, 64'd17, 1'b0, 4'd10);
    random_words(100, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Sent %0d command words including %0d transforms; %0d results compared.",
             words_sent, runs_sent, checked);
    $display("Covered forward and inverse runs, field extremes and all rejection paths.");
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ntt_pkg.sv
hw/rtl/ntt_mulmod.sv
hw/rtl/number_theoretic_transform_core.sv
verif/number_theoretic_transform_checker.sv
verif/number_theoretic_transform_core_test.sv
